// ===== hdl/msm_pkg.sv =====
package msm_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int LOG_W   = 32;
    localparam int FAC_W   = 16;
    localparam int PROB_W  = 17;
    localparam int IDX_W   = 6;
    localparam int VAL_W   = 42;
    localparam int ARG_W   = 21;
    localparam int SUM_W   = 23;
    localparam int NUM_W   = 34;
    localparam int DEN_W   = 23;
    localparam int CFG_IDX_W = 1;

    localparam logic [PROB_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0]       LOG2E_Q16 = 17'd94548;
    localparam logic [ARG_W-1:0]  ARG_CAP   = 21'h1FFFFF;
    localparam logic [FAC_W-1:0]  FAC_RESET = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 1'b0,
        REG_FACTOR = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_LOAD, S_UNI_GO, S_UNI_WT, S_MX, S_RD, S_DAT,
        S_DIFF, S_EXPW, S_QW, S_NW, S_OW, S_EMIT
    } t_state;

    typedef enum logic [1:0] {P_EXP, P_NRM, P_Q, P_OUT} t_pass;
    typedef enum logic [1:0] {K_DIV, K_ZERO, K_UNIF} t_kind;

    // Q0.16 values of 2^(-2^-k), k = 1 .. 16
    function automatic logic [15:0] pow2_frac(input logic [3:0] k);
        logic [15:0] v;
        case (k)
            4'd0:  v = 16'd46341;
            4'd1:  v = 16'd55109;
            4'd2:  v = 16'd60097;
            4'd3:  v = 16'd62757;
            4'd4:  v = 16'd64132;
            4'd5:  v = 16'd64830;
            4'd6:  v = 16'd65182;
            4'd7:  v = 16'd65359;
            4'd8:  v = 16'd65447;
            4'd9:  v = 16'd65492;
            4'd10: v = 16'd65514;
            4'd11: v = 16'd65525;
            4'd12: v = 16'd65530;
            4'd13: v = 16'd65533;
            default: v = 16'd65535;
        endcase
        return v;
    endfunction

    // floor(v * f / 256), or plain sign extension in inverse mode
    function automatic logic signed [VAL_W-1:0] temper_val(
        input logic signed [LOG_W-1:0] v,
        input logic [FAC_W-1:0] f,
        input logic mode
    );
        logic signed [48:0] prod;
        prod = v * $signed({1'b0, f});
        if (mode)
            return VAL_W'(v);
        return VAL_W'(prod >>> 8);
    endfunction

endpackage

// ===== hdl/msm_in_if.sv =====
interface msm_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] log_prob;
    logic        is_neg_inf;
    logic        valid_req;
    logic        last;

    modport source (output valid, log_prob, is_neg_inf, valid_req, last, input ready);
    modport sink   (input valid, log_prob, is_neg_inf, valid_req, last, output ready);
endinterface

// ===== hdl/msm_out_if.sv =====
interface msm_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] prob;
    logic [5:0]  entry_index;
    logic        status;
    logic        last_out;

    modport source (output valid, prob, entry_index, status, last_out, input ready);
    modport sink   (input valid, prob, entry_index, status, last_out, output ready);
endinterface

// ===== hdl/msm_exp.sv =====
module msm_exp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [msm_pkg::ARG_W-1:0]    i_arg,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [msm_pkg::PROB_W-1:0]   o_res
);
    logic [37:0] t_full;
    logic [33:0] step_prod;
    logic [15:0] r_f;
    logic [5:0]  r_n;
    logic [msm_pkg::PROB_W-1:0] r_r;
    logic [3:0]  r_k;
    logic        r_busy;
    logic        r_done;

    // convert to base two: t = m * log2(e)
    assign t_full    = i_arg * msm_pkg::LOG2E_Q16;
    assign step_prod = r_r * msm_pkg::pow2_frac(r_k) + 34'd32768;

    // one fraction bit per cycle, half bit first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_r    <= msm_pkg::ONE_Q16;
                r_f    <= t_full[31:16];
                r_n    <= t_full[37:32];
            end else if (r_busy) begin
                if (r_f[15])
                    r_r <= step_prod[32:16];
                r_f <= {r_f[14:0], 1'b0};
                r_k <= r_k + 4'd1;
                if (r_k == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_res  = (r_n >= 6'd17) ? '0 : (r_r >> r_n);
endmodule

// ===== hdl/msm_div.sv =====
module msm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [msm_pkg::NUM_W-1:0]   i_num,
    input  logic [msm_pkg::DEN_W-1:0]   i_den,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [msm_pkg::NUM_W-1:0]   o_quo
);
    logic [msm_pkg::NUM_W-1:0] r_quo;
    logic [msm_pkg::DEN_W-1:0] r_den;
    logic [msm_pkg::DEN_W:0]   r_rem;
    logic [msm_pkg::DEN_W:0]   rem_sh;
    logic [5:0] r_cnt;
    logic       r_busy;
    logic       r_done;
    logic       fit;

    assign rem_sh = {r_rem[msm_pkg::DEN_W-1:0], r_quo[msm_pkg::NUM_W-1]};
    assign fit    = rem_sh >= {1'b0, r_den};

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_rem <= fit ? rem_sh - {1'b0, r_den} : rem_sh;
                r_quo <= {r_quo[msm_pkg::NUM_W-2:0], fit};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(msm_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== hdl/masked_tempered_softmax.sv =====
// Channel  | Dir | Transfer             | Payload
// i_in     | in  | valid & ready        | log_prob, is_neg_inf, valid_req, last
// o_out    | out | valid & ready        | prob, entry_index, status, last_out
// i_cfg_*  | in  | i_cfg_we             | i_cfg_idx, i_cfg_data
// Loading accepts entries while in the load state; the entry with last starts the passes.
// Exponent pass: each finite valid entry runs through the shared 16-step exp unit; others skip it.
// Output pass: each entry is divided in the shared 34-step divider; inverse mode adds two
// passes that use it for every entry; without division it is skipped; input is held off meanwhile.
// Reset is synchronous, active low, and clears control state only.
// A stalled result holds the sequencer in its emit step.
module masked_tempered_softmax #(
    parameter int MAX_ENTRIES = msm_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    msm_in_if.sink                          i_in,
    msm_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [msm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [msm_pkg::FAC_W-1:0]       i_cfg_data
);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int LW     = msm_pkg::LOG_W + 2;

    msm_pkg::t_state r_state, n_state;
    msm_pkg::t_pass  r_pass;
    msm_pkg::t_kind  r_kind, n_kind;

    logic [LW-1:0]                log_mem  [MAX_ENTRIES];
    logic [msm_pkg::PROB_W-1:0]   prob_mem [MAX_ENTRIES];
    logic [LW-1:0]                r_rlog;
    logic [msm_pkg::PROB_W-1:0]   r_rprob;

    logic                         r_mode;
    logic [msm_pkg::FAC_W-1:0]    r_fac;
    logic [CNT_W-1:0]             r_cnt, n_cnt, r_vcnt, n_vcnt;
    logic signed [msm_pkg::LOG_W-1:0] r_rmax, n_rmax;
    logic                         r_anyf, n_anyf;
    logic [ADDR_W-1:0]            r_idx;
    logic signed [msm_pkg::VAL_W-1:0] r_mx, r_val, diff;
    logic                         r_live;
    logic [msm_pkg::SUM_W-1:0]    r_sum, r_qsum;
    logic [msm_pkg::PROB_W-1:0]   r_uni, r_res;
    logic                         r_status, n_status;

    logic                         r_ovalid, r_olast, r_ostatus;
    logic [msm_pkg::PROB_W-1:0]   r_oprob;
    logic [msm_pkg::IDX_W-1:0]    r_oidx;

    logic in_acc, in_last, out_free, last_i, adv;
    logic exp_start, exp_busy, exp_done;
    logic [msm_pkg::ARG_W-1:0]  exp_arg;
    logic [msm_pkg::PROB_W-1:0] exp_res;
    logic div_start, div_busy, div_done;
    logic [msm_pkg::NUM_W-1:0] div_num, div_quo;
    logic [msm_pkg::DEN_W-1:0] div_den;
    logic [msm_pkg::PROB_W-1:0] sat_quo;
    logic pm_we;
    logic [msm_pkg::PROB_W-1:0] pm_data;
    logic [msm_pkg::PROB_W:0]   q_den;

    assign in_acc   = i_in.valid & i_in.ready;
    assign in_last  = in_acc & i_in.last;
    assign out_free = !r_ovalid || o_out.ready;
    assign last_i   = (CNT_W'(r_idx) + CNT_W'(1)) == r_cnt;
    assign q_den    = {1'b0, msm_pkg::ONE_Q16} + {1'b0, r_rprob};
    assign diff     = r_mx - r_val;
    assign exp_arg  = (diff > msm_pkg::VAL_W'(msm_pkg::ARG_CAP)) ? msm_pkg::ARG_CAP
                                                                  : diff[msm_pkg::ARG_W-1:0];
    // normalized quotient, saturated at 1.0
    assign sat_quo  = (div_quo > msm_pkg::NUM_W'(msm_pkg::ONE_Q16)) ? msm_pkg::ONE_Q16
                                                                    : div_quo[msm_pkg::PROB_W-1:0];

    // statistics including the item being loaded
    always_comb begin
        n_cnt  = r_cnt;
        n_vcnt = r_vcnt;
        n_rmax = r_rmax;
        n_anyf = r_anyf;
        if (in_acc && r_cnt < CNT_W'(MAX_ENTRIES)) begin
            n_cnt = r_cnt + CNT_W'(1);
            if (i_in.valid_req) begin
                n_vcnt = r_vcnt + CNT_W'(1);
                if (!i_in.is_neg_inf) begin
                    n_anyf = 1'b1;
                    if (!r_anyf || $signed(i_in.log_prob) > r_rmax)
                        n_rmax = $signed(i_in.log_prob);
                end
            end
        end
        n_status = 1'b0;
        if (n_vcnt == '0)
            n_kind = msm_pkg::K_ZERO;
        else if (!n_anyf)
            n_kind = msm_pkg::K_UNIF;
        else if (!r_mode && r_fac == '0) begin
            n_kind   = msm_pkg::K_ZERO;
            n_status = 1'b1;
        end else
            n_kind = msm_pkg::K_DIV;
    end

    // sequencer outputs
    always_comb begin
        exp_start = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        pm_we     = 1'b0;
        pm_data   = '0;
        adv       = 1'b0;
        unique case (r_state)
            msm_pkg::S_UNI_GO: begin
                div_start = 1'b1;
                div_num   = msm_pkg::NUM_W'(msm_pkg::ONE_Q16) + msm_pkg::NUM_W'(r_vcnt >> 1);
                div_den   = msm_pkg::DEN_W'(r_vcnt);
            end
            msm_pkg::S_DAT: begin
                if (r_pass == msm_pkg::P_Q) begin
                    div_start = 1'b1;
                    div_num   = {1'b0, r_rprob, 16'd0} + msm_pkg::NUM_W'(q_den >> 1);
                    div_den   = msm_pkg::DEN_W'(q_den);
                end else if (r_pass == msm_pkg::P_NRM ||
                             (r_pass == msm_pkg::P_OUT && r_kind == msm_pkg::K_DIV)) begin
                    div_start = 1'b1;
                    div_num   = {1'b0, r_rprob, 16'd0} + msm_pkg::NUM_W'(r_sum >> 1);
                    div_den   = r_sum;
                end
            end
            msm_pkg::S_DIFF: begin
                exp_start = r_live;
                pm_we     = !r_live;
                adv       = !r_live;
            end
            msm_pkg::S_EXPW: begin
                pm_we   = exp_done;
                pm_data = exp_res;
                adv     = exp_done;
            end
            msm_pkg::S_QW: begin
                pm_we   = div_done;
                pm_data = div_quo[msm_pkg::PROB_W-1:0];
                adv     = div_done;
            end
            msm_pkg::S_NW: begin
                pm_we   = div_done;
                pm_data = sat_quo;
                adv     = div_done;
            end
            msm_pkg::S_EMIT: adv = out_free;
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msm_pkg::S_LOAD: begin
                if (in_last) begin
                    if (n_kind == msm_pkg::K_UNIF)
                        n_state = msm_pkg::S_UNI_GO;
                    else if (n_kind == msm_pkg::K_DIV)
                        n_state = msm_pkg::S_MX;
                    else
                        n_state = msm_pkg::S_RD;
                end
            end
            msm_pkg::S_UNI_GO: n_state = msm_pkg::S_UNI_WT;
            msm_pkg::S_UNI_WT: if (div_done) n_state = msm_pkg::S_RD;
            msm_pkg::S_MX:     n_state = msm_pkg::S_RD;
            msm_pkg::S_RD:     n_state = msm_pkg::S_DAT;
            msm_pkg::S_DAT: begin
                if (r_pass == msm_pkg::P_EXP)
                    n_state = msm_pkg::S_DIFF;
                else if (r_pass == msm_pkg::P_NRM)
                    n_state = msm_pkg::S_NW;
                else if (r_pass == msm_pkg::P_Q)
                    n_state = msm_pkg::S_QW;
                else if (r_kind == msm_pkg::K_DIV)
                    n_state = msm_pkg::S_OW;
                else
                    n_state = msm_pkg::S_EMIT;
            end
            msm_pkg::S_DIFF:   if (r_live) n_state = msm_pkg::S_EXPW;
            msm_pkg::S_OW:     if (div_done) n_state = msm_pkg::S_EMIT;
            default: ;
        endcase
        if (adv)
            n_state = (last_i && r_pass == msm_pkg::P_OUT) ? msm_pkg::S_LOAD : msm_pkg::S_RD;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_fac  <= msm_pkg::FAC_RESET;
        end else if (i_cfg_we) begin
            unique case (msm_pkg::t_reg'(i_cfg_idx))
                msm_pkg::REG_MODE:   r_mode <= i_cfg_data[0];
                msm_pkg::REG_FACTOR: r_fac  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // entry stores: write on load or pass, registered read
    always_ff @(posedge i_clk) begin
        if (in_acc && r_cnt < CNT_W'(MAX_ENTRIES))
            log_mem[r_cnt[ADDR_W-1:0]] <= {i_in.valid_req, i_in.is_neg_inf, i_in.log_prob};
        if (pm_we)
            prob_mem[r_idx] <= pm_data;
        if (r_state == msm_pkg::S_RD) begin
            r_rlog  <= log_mem[r_idx];
            r_rprob <= prob_mem[r_idx];
        end
    end

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= msm_pkg::S_LOAD;
            r_pass   <= msm_pkg::P_OUT;
            r_kind   <= msm_pkg::K_ZERO;
            r_cnt    <= '0;
            r_vcnt   <= '0;
            r_rmax   <= {1'b1, {(msm_pkg::LOG_W-1){1'b0}}};
            r_anyf   <= 1'b0;
            r_idx    <= '0;
            r_status <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == msm_pkg::S_LOAD) begin
                r_cnt  <= n_cnt;
                r_vcnt <= n_vcnt;
                r_rmax <= n_rmax;
                r_anyf <= n_anyf;
                if (in_last) begin
                    r_kind   <= n_kind;
                    r_status <= n_status;
                    r_pass   <= (n_kind == msm_pkg::K_DIV) ? msm_pkg::P_EXP : msm_pkg::P_OUT;
                    r_idx    <= '0;
                    r_sum    <= '0;
                end
            end
            if (r_state == msm_pkg::S_UNI_WT && div_done)
                r_uni <= div_quo[msm_pkg::PROB_W-1:0];
            if (r_state == msm_pkg::S_MX)
                r_mx <= msm_pkg::temper_val(r_rmax, r_fac, r_mode);
            if (r_state == msm_pkg::S_DAT) begin
                r_live <= r_rlog[LW-1] && !r_rlog[LW-2];
                r_val  <= msm_pkg::temper_val(r_rlog[msm_pkg::LOG_W-1:0], r_fac, r_mode);
                if (r_kind == msm_pkg::K_UNIF)
                    r_res <= r_rlog[LW-1] ? r_uni : '0;
                else
                    r_res <= '0;
            end
            if (r_state == msm_pkg::S_EXPW && exp_done)
                r_sum <= r_sum + msm_pkg::SUM_W'(exp_res);
            if (r_state == msm_pkg::S_QW && div_done)
                r_qsum <= r_qsum + msm_pkg::SUM_W'(div_quo[msm_pkg::PROB_W-1:0]);
            if (r_state == msm_pkg::S_OW && div_done)
                r_res <= sat_quo;
            // advance entry and pass
            if (adv) begin
                if (!last_i)
                    r_idx <= r_idx + ADDR_W'(1);
                else begin
                    r_idx <= '0;
                    unique case (r_pass)
                        msm_pkg::P_EXP: begin
                            r_pass <= r_mode ? msm_pkg::P_NRM : msm_pkg::P_OUT;
                            r_qsum <= '0;
                        end
                        msm_pkg::P_NRM: r_pass <= msm_pkg::P_Q;
                        msm_pkg::P_Q: begin
                            r_pass <= msm_pkg::P_OUT;
                            r_sum  <= r_qsum + msm_pkg::SUM_W'(div_quo[msm_pkg::PROB_W-1:0]);
                        end
                        default: begin
                            r_cnt  <= '0;
                            r_vcnt <= '0;
                            r_rmax <= {1'b1, {(msm_pkg::LOG_W-1){1'b0}}};
                            r_anyf <= 1'b0;
                        end
                    endcase
                end
            end
            // output register
            if (r_state == msm_pkg::S_EMIT && out_free) begin
                r_ovalid  <= 1'b1;
                r_oprob   <= r_res;
                r_oidx    <= msm_pkg::IDX_W'(r_idx);
                r_ostatus <= r_status;
                r_olast   <= last_i;
            end else if (o_out.ready)
                r_ovalid <= 1'b0;
        end
    end

    msm_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (exp_start),
        .i_arg   (exp_arg),
        .o_busy  (exp_busy),
        .o_done  (exp_done),
        .o_res   (exp_res)
    );

    msm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign i_in.ready        = (r_state == msm_pkg::S_LOAD);
    assign o_out.valid       = r_ovalid;
    assign o_out.prob        = r_oprob;
    assign o_out.entry_index = r_oidx;
    assign o_out.status      = r_ostatus;
    assign o_out.last_out    = r_olast;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_ENTRIES)) else $error("entry count past depth");
    a_vcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= r_cnt) else $error("valid count above entry count");
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy) else $error("divider restarted while busy");
    a_exp_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exp_start |-> !exp_busy) else $error("exp unit restarted while busy");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msm_pkg::S_EMIT && out_free) |=> r_ovalid)
        else $error("emitted result not presented");
endmodule
